>>> hw/rtl/falu_pkg.sv
// Shared operation and status codes for the fixed-point ALU.
package falu_pkg;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_SUB     = 3'd1,
		OP_MUL     = 3'd2,
		OP_DIV     = 3'd3,
		OP_TO_FIX  = 3'd4,
		OP_TO_INT  = 3'd5
	} op_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_OVF  = 2'd1;
	localparam status_t ST_DIVZ = 2'd2;

endpackage

>>> hw/rtl/fixed_point_alu_top.sv
// Pipelined signed fixed-point ALU (add, subtract, multiply, divide, conversions).
//
// Usage:
//   Requests arrive on the s_ stream: s_tdata carries a 3-bit mode and two signed
//   64-bit operands. Each request yields exactly one response on the m_ stream:
//   a 64-bit result and a 2-bit status (ok, overflow, divide by zero).
//   Values are signed fixed point with FRAC_BITS fraction bits (Q48.16 at default).
//
// Latency and throughput:
//   Every mode travels the same pipeline of FRAC_BITS + 66 register stages
//   (82 at the default), so responses leave in request order. A new request
//   is taken every cycle. The depth is set by the divider, which retires one
//   quotient bit per stage over the 64 + FRAC_BITS bits of (|a| << FRAC_BITS).
//   The multiplier uses four 32x32 partial products, summed one stage later.
//
// Reset: arst_n clears all stage valid bits; no request is in flight after it.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated. Bubbles do not block
//   flow: an empty output stage always lets the pipeline advance.
module fixed_point_alu_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // [2:0] mode, [66:3] operand_a, [130:67] operand_b, rest zero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // [63:0] result, [65:64] status, rest zero
);
	import falu_pkg::*;

	localparam int QW = 64 + FRAC_BITS;  // quotient / numerator width
	localparam int NS = QW + 2;          // pipeline stages

	typedef struct packed {
		logic [2:0]    mode;
		logic          neg;
		logic          divz;
		logic [63:0]   ma;
		logic [63:0]   mb;
		logic [QW-1:0] num;
		logic [63:0]   rem;
		logic [QW-1:0] quo;
		logic [63:0]   pp_ll;
		logic [63:0]   pp_lh;
		logic [63:0]   pp_hl;
		logic [63:0]   pp_hh;
		logic [127:0]  prod;
		logic [63:0]   res;
		status_t       st;
	} stage_t;

	stage_t pl_s  [NS];
	logic   vld_s [NS];
	stage_t nx    [NS];
	logic   en;

	// Advance whenever the output stage is empty or being taken.
	assign en       = !vld_s[NS-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[NS-1];
	assign m_tdata  = {6'd0, pl_s[NS-1].st, pl_s[NS-1].res};

	// Entry stage: decode, magnitudes, and the add, subtract and conversion operations.
	always_comb begin
		logic [63:0] a, b, r;
		logic [2:0]  md;
		a  = s_tdata[66:3];
		b  = s_tdata[130:67];
		md = s_tdata[2:0];
		r  = '0;
		nx[0]       = '0;
		nx[0].mode  = md;
		nx[0].neg   = a[63] ^ b[63];
		nx[0].divz  = (b == 64'd0);
		nx[0].ma    = a[63] ? (~a + 64'd1) : a;
		nx[0].mb    = b[63] ? (~b + 64'd1) : b;
		nx[0].num   = {{(QW-64){1'b0}}, nx[0].ma} << FRAC_BITS;
		nx[0].res   = '0;
		nx[0].st    = ST_OK;
		unique case (md)
			OP_ADD: begin
				r = a + b;
				nx[0].res = r;
				nx[0].st  = ((a[63] ^ r[63]) && (b[63] ^ r[63])) ? ST_OVF : ST_OK;
			end
			OP_SUB: begin
				r = a - b;
				nx[0].res = r;
				nx[0].st  = ((a[63] ^ b[63]) && (a[63] ^ r[63])) ? ST_OVF : ST_OK;
			end
			OP_TO_FIX: begin
				r = a << FRAC_BITS;
				nx[0].res = r;
				nx[0].st  = (($signed(r) >>> FRAC_BITS) == $signed(a)) ? ST_OK : ST_OVF;
			end
			OP_TO_INT: begin
				nx[0].res = 64'($signed(a) >>> FRAC_BITS);
			end
			default: begin
				nx[0].res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0] <= nx[0];
		end
	end

	genvar k;
	generate
		for (k = 1; k < NS; k++) begin : g_stage
			always_comb begin
				logic [63:0]    rs;
				logic [127:0]   pn;
				logic [127:0]   sh;
				logic           ok;
				logic [QW-1:0]  q;
				nx[k] = pl_s[k-1];
				rs = '0;
				pn = '0;
				sh = '0;
				ok = 1'b0;
				q  = pl_s[k-1].quo;
				// One restoring-divide bit per stage.
				if (k <= QW) begin
					rs = {pl_s[k-1].rem[62:0], pl_s[k-1].num[QW-1]};
					nx[k].num = pl_s[k-1].num << 1;
					if (rs >= pl_s[k-1].mb) begin
						nx[k].rem = rs - pl_s[k-1].mb;
						nx[k].quo = {pl_s[k-1].quo[QW-2:0], 1'b1};
					end else begin
						nx[k].rem = rs;
						nx[k].quo = {pl_s[k-1].quo[QW-2:0], 1'b0};
					end
				end
				// Multiplier: partial products, sum, then sign and scale.
				if (k == 1) begin
					nx[k].pp_ll = pl_s[k-1].ma[31:0]  * pl_s[k-1].mb[31:0];
					nx[k].pp_lh = pl_s[k-1].ma[31:0]  * pl_s[k-1].mb[63:32];
					nx[k].pp_hl = pl_s[k-1].ma[63:32] * pl_s[k-1].mb[31:0];
					nx[k].pp_hh = pl_s[k-1].ma[63:32] * pl_s[k-1].mb[63:32];
				end
				if (k == 2) begin
					nx[k].prod = {pl_s[k-1].pp_hh, 64'd0}
						+ ({64'd0, pl_s[k-1].pp_lh} << 32)
						+ ({64'd0, pl_s[k-1].pp_hl} << 32)
						+ {64'd0, pl_s[k-1].pp_ll};
				end
				if (k == 3 && pl_s[k-1].mode == OP_MUL) begin
					pn = pl_s[k-1].neg ? (~pl_s[k-1].prod + 128'd1) : pl_s[k-1].prod;
					sh = 128'($signed(pn) >>> FRAC_BITS);
					nx[k].res = sh[63:0];
					nx[k].st  = (sh[127:64] == {64{sh[63]}}) ? ST_OK : ST_OVF;
				end
				// Divide finish: apply sign, check range, handle zero divisor.
				if (k == NS-1 && pl_s[k-1].mode == OP_DIV) begin
					if (pl_s[k-1].divz) begin
						nx[k].res = '0;
						nx[k].st  = ST_DIVZ;
					end else if (pl_s[k-1].neg) begin
						ok = (q[QW-1:64] == '0) && (q[63:0] <= {1'b1, 63'd0});
						nx[k].res = ~q[63:0] + 64'd1;
						nx[k].st  = ok ? ST_OK : ST_OVF;
					end else begin
						ok = (q[QW-1:63] == '0);
						nx[k].res = q[63:0];
						nx[k].st  = ok ? ST_OK : ST_OVF;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					pl_s[k] <= nx[k];
				end
			end
		end
	endgenerate

endmodule
